[rtl/ttg_pkg.sv]
package ttg_pkg;

    // fixed-point layout of the internal vectors
    localparam int DirTop    = 19;   // scaled tangent/binormal top bit
    localparam int OrthTop   = 29;   // scaled orthogonal tangent top bit
    localparam int OrthShift = 28;   // tangent weight in the gram-schmidt step
    localparam int FracBits  = 14;   // Q1.14 output fraction
    localparam int LenW      = 31;   // square root result width
    localparam int SumW      = 62;   // sum of squares width
    localparam int QuotW     = 15;   // quotient width, at most 16384

    localparam logic [15:0] DefThreshold = 16'd32;

    // sign and magnitude vector at direction scale
    typedef struct packed {
        logic [2:0]              sgn;
        logic [2:0][DirTop:0]    mag;
    } dir_t;

    // sign and magnitude vector at orthogonal scale
    typedef struct packed {
        logic [2:0]              sgn;
        logic [2:0][OrthTop:0]   mag;
    } orth_t;

    // per-item data that rides alongside the main datapath
    typedef struct packed {
        logic                    deg;
        logic [2:0][15:0]        nrm;
        dir_t                    bin;
    } side_t;

endpackage

[rtl/ttg_setup.sv]
module ttg_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    input  logic [47:0]     pos_a,
    input  logic [47:0]     pos_b,
    input  logic [47:0]     pos_c,
    input  logic [31:0]     uv_a,
    input  logic [31:0]     uv_b,
    input  logic [31:0]     uv_c,
    input  logic [47:0]     face_normal,
    input  logic [15:0]     thr,
    output logic            out_vld,
    output ttg_pkg::dir_t   tang,
    output ttg_pkg::side_t  side
);
    import ttg_pkg::*;

    localparam int PW  = 3 * COORD_BITS;
    localparam int EW  = COORD_BITS + 1;
    localparam int MW  = COORD_BITS + 18;
    localparam int TW  = COORD_BITS + 19;
    localparam int PSW = $clog2(TW);

    function automatic logic [PSW-1:0] msb_of(input logic [TW-1:0] x);
        logic [PSW-1:0] p;
        p = '0;
        for (int j = 0; j < TW; j++)
        begin
            if (x[j])
            begin
                p = PSW'(j);
            end
        end
        return p;
    endfunction

    logic [5:0] vld_reg;

    logic [PW+47:0] pa_w, pb_w, pc_w;
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [16:0] s1_reg, t1_reg, s2_reg, t2_reg;

    logic signed [33:0] dp1_reg, dp2_reg;
    logic signed [MW-1:0] tp1_reg [3];
    logic signed [MW-1:0] tp2_reg [3];
    logic signed [MW-1:0] bp1_reg [3];
    logic signed [MW-1:0] bp2_reg [3];

    logic signed [34:0] det_reg;
    logic signed [TW-1:0] tv_reg [3];
    logic signed [TW-1:0] bv_reg [3];

    logic [34:0] det_mag;
    logic deg_next;
    logic [TW-1:0] tabs [3];
    logic [TW-1:0] babs [3];
    logic [TW-1:0] tm_next [3];
    logic [TW-1:0] bm_next [3];
    logic [2:0] ts_next, bs_next;
    logic [TW-1:0] tm_reg [3];
    logic [TW-1:0] bm_reg [3];
    logic [2:0] ts_reg, bs_reg;
    logic deg4_reg;

    logic [TW-1:0] tm5_reg [3];
    logic [TW-1:0] bm5_reg [3];
    logic [2:0] ts5_reg, bs5_reg;
    logic [PSW-1:0] tp5_reg, bp5_reg;
    logic deg5_reg;

    logic [TW+DirTop-1:0] twide [3];
    logic [TW+DirTop-1:0] bwide [3];
    dir_t tang_next, bin_next;
    dir_t tang_reg;
    side_t side_reg;

    logic [47:0] n1_reg, n2_reg, n3_reg, n4_reg, n5_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    // lane extraction and differences
    assign pa_w = (PW + 48)'(pos_a);
    assign pb_w = (PW + 48)'(pos_b);
    assign pc_w = (PW + 48)'(pos_c);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i] = EW'($signed(pb_w[i*COORD_BITS +: COORD_BITS]))
                       - EW'($signed(pa_w[i*COORD_BITS +: COORD_BITS]));
            e2_next[i] = EW'($signed(pc_w[i*COORD_BITS +: COORD_BITS]))
                       - EW'($signed(pa_w[i*COORD_BITS +: COORD_BITS]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_reg[i] <= e1_next[i];
            e2_reg[i] <= e2_next[i];
        end
        s1_reg <= 17'($signed(uv_b[15:0])) - 17'($signed(uv_a[15:0]));
        t1_reg <= 17'($signed(uv_b[31:16])) - 17'($signed(uv_a[31:16]));
        s2_reg <= 17'($signed(uv_c[15:0])) - 17'($signed(uv_a[15:0]));
        t2_reg <= 17'($signed(uv_c[31:16])) - 17'($signed(uv_a[31:16]));
        n1_reg <= face_normal;
    end

    // products for determinant, tangent and binormal
    always_ff @(posedge clk)
    begin
        dp1_reg <= 34'(s1_reg) * 34'(t2_reg);
        dp2_reg <= 34'(s2_reg) * 34'(t1_reg);
        for (int i = 0; i < 3; i++)
        begin
            tp1_reg[i] <= MW'(t2_reg) * MW'(e1_reg[i]);
            tp2_reg[i] <= MW'(t1_reg) * MW'(e2_reg[i]);
            bp1_reg[i] <= MW'(s1_reg) * MW'(e2_reg[i]);
            bp2_reg[i] <= MW'(s2_reg) * MW'(e1_reg[i]);
        end
        n2_reg <= n1_reg;
    end

    // differences of products
    always_ff @(posedge clk)
    begin
        det_reg <= 35'(dp1_reg) - 35'(dp2_reg);
        for (int i = 0; i < 3; i++)
        begin
            tv_reg[i] <= TW'(tp1_reg[i]) - TW'(tp2_reg[i]);
            bv_reg[i] <= TW'(bp1_reg[i]) - TW'(bp2_reg[i]);
        end
        n3_reg <= n2_reg;
    end

    // degenerate test and default selection
    always_comb
    begin
        det_mag  = det_reg[34] ? 35'(-det_reg) : 35'(det_reg);
        deg_next = (det_reg == '0) || (det_mag < 35'(thr));
        for (int i = 0; i < 3; i++)
        begin
            tabs[i] = tv_reg[i][TW-1] ? TW'(-tv_reg[i]) : TW'(tv_reg[i]);
            babs[i] = bv_reg[i][TW-1] ? TW'(-bv_reg[i]) : TW'(bv_reg[i]);
            if (deg_next)
            begin
                tm_next[i] = (i == 0) ? TW'(1) : '0;
                bm_next[i] = (i == 1) ? TW'(1) : '0;
                ts_next[i] = 1'b0;
                bs_next[i] = 1'b0;
            end
            else
            begin
                tm_next[i] = tabs[i];
                bm_next[i] = babs[i];
                ts_next[i] = tv_reg[i][TW-1] ^ det_reg[34];
                bs_next[i] = bv_reg[i][TW-1] ^ det_reg[34];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tm_reg   <= tm_next;
        bm_reg   <= bm_next;
        ts_reg   <= ts_next;
        bs_reg   <= bs_next;
        deg4_reg <= deg_next;
        n4_reg   <= n3_reg;
    end

    // leading one of the largest component
    always_ff @(posedge clk)
    begin
        tm5_reg  <= tm_reg;
        bm5_reg  <= bm_reg;
        ts5_reg  <= ts_reg;
        bs5_reg  <= bs_reg;
        tp5_reg  <= msb_of(tm_reg[0] | tm_reg[1] | tm_reg[2]);
        bp5_reg  <= msb_of(bm_reg[0] | bm_reg[1] | bm_reg[2]);
        deg5_reg <= deg4_reg;
        n5_reg   <= n4_reg;
    end

    // scale so the top bit lands on the direction scale
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            twide[i] = ((TW + DirTop)'(tm5_reg[i]) << DirTop) >> tp5_reg;
            bwide[i] = ((TW + DirTop)'(bm5_reg[i]) << DirTop) >> bp5_reg;
            tang_next.mag[i] = twide[i][DirTop:0];
            bin_next.mag[i]  = bwide[i][DirTop:0];
        end
        tang_next.sgn = ts5_reg;
        bin_next.sgn  = bs5_reg;
    end

    always_ff @(posedge clk)
    begin
        tang_reg     <= tang_next;
        side_reg.deg <= deg5_reg;
        side_reg.nrm <= n5_reg;
        side_reg.bin <= bin_next;
    end

    assign out_vld = vld_reg[5];
    assign tang    = tang_reg;
    assign side    = side_reg;

endmodule

[rtl/ttg_ortho.sv]
module ttg_ortho (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_vld,
    input  ttg_pkg::dir_t             tang,
    input  ttg_pkg::side_t            side_in,
    output logic                      out_vld,
    output logic [ttg_pkg::SumW-1:0]  sum,
    output ttg_pkg::orth_t            orth,
    output ttg_pkg::side_t            side_out
);
    import ttg_pkg::*;

    localparam int TsW = DirTop + 2;
    localparam int PtW = TsW + 16;
    localparam int DtW = PtW + 2;
    localparam int NdW = DtW + 16;
    localparam int GW  = NdW + 1;
    localparam int GmW = GW - 1;
    localparam int GpW = $clog2(GmW);
    localparam int OmW = OrthTop + 1;

    function automatic logic [GpW-1:0] msb_of(input logic [GmW-1:0] x);
        logic [GpW-1:0] p;
        p = '0;
        for (int j = 0; j < GmW; j++)
        begin
            if (x[j])
            begin
                p = GpW'(j);
            end
        end
        return p;
    endfunction

    logic [7:0] vld_reg;
    side_t side_reg [1:8];

    logic signed [TsW-1:0] tsv [3];
    logic signed [TsW-1:0] ts1_reg [3];
    logic signed [TsW-1:0] ts2_reg [3];
    logic signed [TsW-1:0] ts3_reg [3];
    logic signed [PtW-1:0] pt_reg [3];
    logic signed [DtW-1:0] dot_reg;
    logic signed [NdW-1:0] nd_reg [3];

    logic signed [GW-1:0] g [3];
    logic [GmW-1:0] gm_next [3];
    logic [GmW-1:0] gm_reg [3];
    logic [GmW-1:0] gm5_reg [3];
    logic [2:0] gs_next, gs_reg, gs5_reg;
    logic [GpW-1:0] gp5_reg;

    logic [GmW+OrthTop-1:0] gwide [3];
    orth_t orth_next;
    orth_t orth6_reg, orth7_reg, orth8_reg;
    logic [2*OmW-1:0] sq_reg [3];
    logic [SumW-1:0] sum_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[6:0], in_vld};
        end
    end

    // side data follows the stages
    always_ff @(posedge clk)
    begin
        side_reg[1] <= side_in;
        for (int k = 2; k <= 8; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // tangent times normal, per component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tsv[i] = tang.sgn[i] ? -TsW'(tang.mag[i]) : TsW'(tang.mag[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt_reg[i]  <= PtW'(tsv[i]) * PtW'($signed(side_in.nrm[i]));
            ts1_reg[i] <= tsv[i];
        end
    end

    // dot product
    always_ff @(posedge clk)
    begin
        dot_reg <= DtW'(pt_reg[0]) + DtW'(pt_reg[1]) + DtW'(pt_reg[2]);
        ts2_reg <= ts1_reg;
    end

    // normal times dot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nd_reg[i] <= NdW'($signed(side_reg[2].nrm[i])) * NdW'(dot_reg);
        end
        ts3_reg <= ts2_reg;
    end

    // gram-schmidt step into sign and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g[i]       = (GW'(ts3_reg[i]) <<< OrthShift) - GW'(nd_reg[i]);
            gs_next[i] = g[i][GW-1];
            gm_next[i] = g[i][GW-1] ? GmW'(-g[i]) : GmW'(g[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        gm_reg <= gm_next;
        gs_reg <= gs_next;
    end

    // leading one of the largest component
    always_ff @(posedge clk)
    begin
        gm5_reg <= gm_reg;
        gs5_reg <= gs_reg;
        gp5_reg <= msb_of(gm_reg[0] | gm_reg[1] | gm_reg[2]);
    end

    // scale to the orthogonal scale
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            gwide[i] = ((GmW + OrthTop)'(gm5_reg[i]) << OrthTop) >> gp5_reg;
            orth_next.mag[i] = gwide[i][OrthTop:0];
        end
        orth_next.sgn = gs5_reg;
    end

    always_ff @(posedge clk)
    begin
        orth6_reg <= orth_next;
    end

    // squares
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_reg[i] <= (2*OmW)'(orth6_reg.mag[i]) * (2*OmW)'(orth6_reg.mag[i]);
        end
        orth7_reg <= orth6_reg;
    end

    // sum of squares
    always_ff @(posedge clk)
    begin
        sum_reg   <= SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
        orth8_reg <= orth7_reg;
    end

    assign out_vld  = vld_reg[7];
    assign sum      = sum_reg;
    assign orth     = orth8_reg;
    assign side_out = side_reg[8];

endmodule

[rtl/ttg_sqrt.sv]
module ttg_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_vld,
    input  logic [ttg_pkg::SumW-1:0]  sum,
    input  ttg_pkg::orth_t            orth_in,
    input  ttg_pkg::side_t            side_in,
    output logic                      out_vld,
    output logic [ttg_pkg::LenW-1:0]  len,
    output ttg_pkg::orth_t            orth_out,
    output ttg_pkg::side_t            side_out
);
    import ttg_pkg::*;

    localparam int N  = LenW;
    localparam int RW = 2 * LenW + 2;

    logic [RW-1:0]   rem_reg  [1:N];
    logic [LenW-1:0] root_reg [1:N];
    logic            vld_reg  [1:N];
    orth_t           orth_reg [1:N];
    side_t           side_reg [1:N];

    // one result bit per stage, most significant first
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int B = N - 1 - k;

        logic [RW-1:0]   rem_in;
        logic [LenW-1:0] root_in;
        logic            vld_in;
        orth_t           orth_k;
        side_t           side_k;
        logic [RW-1:0]   trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = RW'(sum);
            assign root_in = '0;
            assign vld_in  = in_vld;
            assign orth_k  = orth_in;
            assign side_k  = side_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign vld_in  = vld_reg[k];
            assign orth_k  = orth_reg[k];
            assign side_k  = side_reg[k];
        end

        // trial subtrahend for setting this bit
        assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rem_in >= trial)
            begin
                rem_reg[k+1]  <= rem_in - trial;
                root_reg[k+1] <= root_in | (LenW'(1) << B);
            end
            else
            begin
                rem_reg[k+1]  <= rem_in;
                root_reg[k+1] <= root_in;
            end
            orth_reg[k+1] <= orth_k;
            side_reg[k+1] <= side_k;
        end
    end

    assign out_vld  = vld_reg[N];
    assign len      = root_reg[N];
    assign orth_out = orth_reg[N];
    assign side_out = side_reg[N];

endmodule

[rtl/ttg_div.sv]
module ttg_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_vld,
    input  logic [ttg_pkg::LenW-1:0]  len,
    input  ttg_pkg::orth_t            orth_in,
    input  ttg_pkg::side_t            side_in,
    output logic                      out_vld,
    output logic [2:0][15:0]          vec,
    output logic                      zero,
    output ttg_pkg::side_t            side_out
);
    import ttg_pkg::*;

    localparam int N  = QuotW;
    localparam int DW = LenW + FracBits;

    logic [2:0][DW-1:0]    num_reg;
    logic [LenW-1:0]       len0_reg;
    logic [2:0]            sgn0_reg;
    logic                  zero0_reg;
    logic                  vld0_reg;
    side_t                 side0_reg;

    logic [2:0][DW-1:0]    rem_reg  [1:N];
    logic [2:0][N-1:0]     q_reg    [1:N];
    logic [LenW-1:0]       len_reg  [1:N];
    logic [2:0]            sgn_reg  [1:N];
    logic                  zero_reg [1:N];
    logic                  vld_reg  [1:N];
    side_t                 side_reg [1:N];

    // rounded numerators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= (DW'(orth_in.mag[i]) << FracBits) + DW'(len >> 1);
        end
        len0_reg  <= len;
        sgn0_reg  <= orth_in.sgn;
        zero0_reg <= (len == '0);
        side0_reg <= side_in;
    end

    // restoring division, one quotient bit per stage for all three lanes
    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam int B = N - 1 - k;

        logic [2:0][DW-1:0] rem_in;
        logic [2:0][N-1:0]  q_in;
        logic [LenW-1:0]    len_in;
        logic [2:0]         sgn_in;
        logic               zero_in;
        logic               vld_in;
        side_t              side_k;
        logic [DW-1:0]      dvs;

        if (k == 0)
        begin : g_first
            assign rem_in  = num_reg;
            assign q_in    = '0;
            assign len_in  = len0_reg;
            assign sgn_in  = sgn0_reg;
            assign zero_in = zero0_reg;
            assign vld_in  = vld0_reg;
            assign side_k  = side0_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k];
            assign q_in    = q_reg[k];
            assign len_in  = len_reg[k];
            assign sgn_in  = sgn_reg[k];
            assign zero_in = zero_reg[k];
            assign vld_in  = vld_reg[k];
            assign side_k  = side_reg[k];
        end

        assign dvs = DW'(len_in) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= dvs)
                begin
                    rem_reg[k+1][i] <= rem_in[i] - dvs;
                    q_reg[k+1][i]   <= q_in[i] | (N'(1) << B);
                end
                else
                begin
                    rem_reg[k+1][i] <= rem_in[i];
                    q_reg[k+1][i]   <= q_in[i];
                end
            end
            len_reg[k+1]  <= len_in;
            sgn_reg[k+1]  <= sgn_in;
            zero_reg[k+1] <= zero_in;
            side_reg[k+1] <= side_k;
        end
    end

    // signed components, forced to zero for a zero-length vector
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg[N])
            begin
                vec[i] = '0;
            end
            else if (sgn_reg[N][i])
            begin
                vec[i] = -16'(q_reg[N][i]);
            end
            else
            begin
                vec[i] = 16'(q_reg[N][i]);
            end
        end
    end

    assign out_vld  = vld_reg[N];
    assign zero     = zero_reg[N];
    assign side_out = side_reg[N];

endmodule

[rtl/ttg_hand.sv]
module ttg_hand (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [2:0][15:0]      vec,
    input  logic                  zero,
    input  ttg_pkg::side_t        side_in,
    output logic                  done,
    output logic [47:0]           tangent_vec,
    output logic                  uv_degenerate,
    output logic                  zero_length,
    output logic                  flipped
);
    import ttg_pkg::*;

    localparam int CW  = 33;
    localparam int BsW = DirTop + 2;
    localparam int PcW = CW + BsW;
    localparam int HW  = PcW + 2;

    logic [2:0] vld_reg;
    logic signed [15:0] nv [3];
    logic signed [15:0] ov [3];
    logic signed [CW-1:0] c_reg [3];
    logic [2:0][15:0] vec1_reg, vec2_reg;
    logic zero1_reg, zero2_reg;
    side_t side1_reg, side2_reg;

    logic signed [BsW-1:0] bsv [3];
    logic signed [PcW-1:0] pc_reg [3];

    logic signed [HW-1:0] h;
    logic flip;
    logic [2:0][15:0] tan_next;

    logic [47:0] tan_reg;
    logic deg_reg, zero_reg, flip_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    // normal cross tangent
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = $signed(side_in.nrm[i]);
            ov[i] = $signed(vec[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg[0]  <= CW'(nv[1]) * CW'(ov[2]) - CW'(nv[2]) * CW'(ov[1]);
        c_reg[1]  <= CW'(nv[2]) * CW'(ov[0]) - CW'(nv[0]) * CW'(ov[2]);
        c_reg[2]  <= CW'(nv[0]) * CW'(ov[1]) - CW'(nv[1]) * CW'(ov[0]);
        vec1_reg  <= vec;
        zero1_reg <= zero;
        side1_reg <= side_in;
    end

    // products with the binormal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bsv[i] = side1_reg.bin.sgn[i] ? -BsW'(side1_reg.bin.mag[i])
                                          : BsW'(side1_reg.bin.mag[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pc_reg[i] <= PcW'(c_reg[i]) * PcW'(bsv[i]);
        end
        vec2_reg  <= vec1_reg;
        zero2_reg <= zero1_reg;
        side2_reg <= side1_reg;
    end

    // handedness sign and final negation
    always_comb
    begin
        h    = HW'(pc_reg[0]) + HW'(pc_reg[1]) + HW'(pc_reg[2]);
        flip = h[HW-1];
        for (int i = 0; i < 3; i++)
        begin
            tan_next[i] = flip ? -vec2_reg[i] : vec2_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        tan_reg  <= tan_next;
        deg_reg  <= side2_reg.deg;
        zero_reg <= zero2_reg;
        flip_reg <= flip;
    end

    assign done          = vld_reg[2];
    assign tangent_vec   = tan_reg;
    assign uv_degenerate = deg_reg;
    assign zero_length   = zero_reg;
    assign flipped       = flip_reg;

endmodule

[rtl/triangle_tangent_generator.sv]
// per-triangle tangent generator
//
// input: one triangle per transfer, taken at a rising edge with start high
// and busy low. busy is always low, so a triangle may be offered in every
// cycle and the pipeline accepts one item per clock.
// output: one result per triangle on tangent_vec and the three flags, shown
// for exactly one cycle with done high. the receiver cannot hold results off
// and none is needed: nothing in the pipeline ever waits.
// pipeline: the sqrt (31 stages, one result bit each) and the divider (one
// rounding stage plus 15 quotient stages) make up most of its depth; the
// rest is products, gram-schmidt, scaling and the handedness test.
// configuration: cfg_we writes cfg_wdata into the degenerate threshold;
// write it only while no triangle is in flight.
// reset: rst_n clears every valid bit and sets the threshold to 32; items in
// flight at reset are dropped.
module triangle_tangent_generator #(
    parameter int COORD_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic [47:0]  pos_a,
    input  logic [47:0]  pos_b,
    input  logic [47:0]  pos_c,
    input  logic [31:0]  uv_a,
    input  logic [31:0]  uv_b,
    input  logic [31:0]  uv_c,
    input  logic [47:0]  face_normal,
    output logic         done,
    output logic [47:0]  tangent_vec,
    output logic         uv_degenerate,
    output logic         zero_length,
    output logic         flipped
);
    import ttg_pkg::*;

    localparam int Lat = 64;

    logic [15:0] thr_reg;

    logic  su_vld;
    dir_t  su_tang;
    side_t su_side;

    logic             or_vld;
    logic [SumW-1:0]  or_sum;
    orth_t            or_orth;
    side_t            or_side;

    logic             sq_vld;
    logic [LenW-1:0]  sq_len;
    orth_t            sq_orth;
    side_t            sq_side;

    logic             dv_vld;
    logic [2:0][15:0] dv_vec;
    logic             dv_zero;
    side_t            dv_side;

    // the pipeline never stalls
    assign busy = 1'b0;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= DefThreshold;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    ttg_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (start && !busy),
        .pos_a       (pos_a),
        .pos_b       (pos_b),
        .pos_c       (pos_c),
        .uv_a        (uv_a),
        .uv_b        (uv_b),
        .uv_c        (uv_c),
        .face_normal (face_normal),
        .thr         (thr_reg),
        .out_vld     (su_vld),
        .tang        (su_tang),
        .side        (su_side)
    );

    ttg_ortho u_ortho (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (su_vld),
        .tang     (su_tang),
        .side_in  (su_side),
        .out_vld  (or_vld),
        .sum      (or_sum),
        .orth     (or_orth),
        .side_out (or_side)
    );

    ttg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (or_vld),
        .sum      (or_sum),
        .orth_in  (or_orth),
        .side_in  (or_side),
        .out_vld  (sq_vld),
        .len      (sq_len),
        .orth_out (sq_orth),
        .side_out (sq_side)
    );

    ttg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (sq_vld),
        .len      (sq_len),
        .orth_in  (sq_orth),
        .side_in  (sq_side),
        .out_vld  (dv_vld),
        .vec      (dv_vec),
        .zero     (dv_zero),
        .side_out (dv_side)
    );

    ttg_hand u_hand (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (dv_vld),
        .vec           (dv_vec),
        .zero          (dv_zero),
        .side_in       (dv_side),
        .done          (done),
        .tangent_vec   (tangent_vec),
        .uv_degenerate (uv_degenerate),
        .zero_length   (zero_length),
        .flipped       (flipped)
    );

`ifndef SYNTHESIS
    // every accepted triangle comes out after the fixed latency
    a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##Lat done)
        else $error("accepted triangle did not complete on time");

    // no result without a triangle accepted at the matching edge
    a_latency_in: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Lat))
        else $error("result without an accepted triangle");

    // a zero-length result is the zero vector and never flipped
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_length |-> (tangent_vec == '0) && !flipped)
        else $error("zero-length result carries data");
`endif

endmodule
